@@ rtl/core/sdw_pkg.sv @@
// ----------------------------------------------------------------------------
// sdw_pkg
// Shared types, codes and helpers for the SD block write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdw_pkg;

	// Sequencer phase
	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_CMD        = 3'd1,
		PH_CMD_STATE  = 3'd2,
		PH_DATA       = 3'd3,
		PH_PROG_STATE = 3'd4,
		PH_TICK       = 3'd5
	} phase_t;

	// Event codes on the item channel
	localparam logic [2:0] CMD_START       = 3'd0;
	localparam logic [2:0] CMD_CMD_REPLY   = 3'd1;
	localparam logic [2:0] CMD_DATA_REPLY  = 3'd2;
	localparam logic [2:0] CMD_STATE_REPLY = 3'd3;
	localparam logic [2:0] CMD_TICK        = 3'd4;

	// Action codes on the result channel
	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_CMD    = 3'd1;
	localparam logic [2:0] ACT_DATA   = 3'd2;
	localparam logic [2:0] ACT_STATE  = 3'd3;
	localparam logic [2:0] ACT_TIMER  = 3'd4;
	localparam logic [2:0] ACT_FINISH = 3'd5;

	// Error codes
	localparam logic [3:0] ERR_NONE     = 4'd0;
	localparam logic [3:0] ERR_CMD_CRC  = 4'd1;
	localparam logic [3:0] ERR_NO_RESP  = 4'd2;
	localparam logic [3:0] ERR_RESP_CRC = 4'd3;
	localparam logic [3:0] ERR_DATA_CRC = 4'd4;
	localparam logic [3:0] ERR_TIMEOUT  = 4'd5;
	localparam logic [3:0] ERR_GENERAL  = 4'd6;

	// Card state codes
	localparam logic [1:0] CST_TRANSFER = 2'd0;
	localparam logic [1:0] CST_RECEIVE  = 2'd1;

	// Configuration register indexes
	localparam logic [1:0] REG_HIGH_CAPACITY   = 2'd0;
	localparam logic [1:0] REG_BLOCK_SIZE_LOG2 = 2'd1;
	localparam logic [1:0] REG_RETRY_LIMIT     = 2'd2;
	localparam logic [1:0] REG_PROGRAM_TIMEOUT = 2'd3;

	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic        high_capacity;
		logic [3:0]  block_size_log2;
		logic [7:0]  retry_limit;
		logic [15:0] program_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] first_block;
		logic [31:0] block_total;
		logic [3:0]  error_code;
		logic [1:0]  card_state;
	} item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] command_argument;
		logic [31:0] data_block_index;
		logic [31:0] blocks_done;
		logic [3:0]  result_error;
	} result_t;

	// Transfer context, except the poll budget whose width is a parameter
	typedef struct packed {
		phase_t      phase;
		logic [31:0] current_block;
		logic [31:0] target_count;
		logic [31:0] done_count;
		logic [7:0]  cmd_tries;
		logic [7:0]  data_tries;
	} ctx_t;

	// A zero retry limit still allows one try
	function automatic logic [7:0] tries_init(input logic [7:0] limit);
		tries_init = (limit == 8'd0) ? 8'd1 : limit;
	endfunction

	// Card address: block number, or byte address for standard capacity
	function automatic logic [31:0] card_addr(input cfg_t cfg, input logic [31:0] blk);
		card_addr = cfg.high_capacity ? blk : (blk << cfg.block_size_log2);
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/sd_block_write_sequencer.sv @@
// ----------------------------------------------------------------------------
// sd_block_write_sequencer
// Sequences single-block SD writes (CMD24) with command and data retries
// and a polled programming timeout. One action per event.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-----------------------
//   item     | in        | item_valid / item_stall    | command .. card_state
//   result   | out       | result_valid / result_stall| action .. result_error
//   cfg      | in        | cfg_we                     | cfg_index, cfg_data
//
// One event is taken every cycle while item_stall is low; a transaction taken into
// the input register moves on into the result register once it is empty or being taken.
// All decode work sits between the input register and the result register.
// Reset clears both valid flags, the phase, the counters and the
// configuration to its defaults.
// A stalled result holds the input register; item_stall rises only while
// that register holds a transaction that cannot move on.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_block_write_sequencer #(
	parameter int POLL_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  command,
	input  logic [31:0] first_block,
	input  logic [31:0] block_total,
	input  logic [3:0]  error_code,
	input  logic [1:0]  card_state,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  action,
	output logic [31:0] command_argument,
	output logic [31:0] data_block_index,
	output logic [31:0] blocks_done,
	output logic [3:0]  result_error,

	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [sdw_pkg::CFG_DATA_W-1:0] cfg_data
);

	sdw_pkg::item_t   item_s1;
	logic             valid_s1;
	sdw_pkg::ctx_t    ctx_q;
	sdw_pkg::ctx_t    ctx_nxt;
	logic [POLL_WIDTH-1:0] poll_q;
	logic [POLL_WIDTH-1:0] poll_nxt;
	sdw_pkg::cfg_t    cfg_q;
	sdw_pkg::result_t res;
	sdw_pkg::result_t result_s2;
	logic             valid_s2;
	logic             advance;
	logic             fire;

	// Stage 1 moves on when the result register is empty or being taken
	assign advance    = !valid_s2 || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_capacity      <= 1'b1;
			cfg_q.block_size_log2    <= 4'd9;
			cfg_q.retry_limit        <= 8'd2;
			cfg_q.program_timeout_ms <= 16'd250;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdw_pkg::REG_HIGH_CAPACITY:   cfg_q.high_capacity      <= cfg_data[0];
				sdw_pkg::REG_BLOCK_SIZE_LOG2: cfg_q.block_size_log2    <= cfg_data[3:0];
				sdw_pkg::REG_RETRY_LIMIT:     cfg_q.retry_limit        <= cfg_data[7:0];
				sdw_pkg::REG_PROGRAM_TIMEOUT: cfg_q.program_timeout_ms <= cfg_data[15:0];
				default:                      cfg_q                    <= cfg_q;
			endcase
		end
	end

	// Input register: take a transaction whenever stage 1 is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1.command     <= command;
			item_s1.first_block <= first_block;
			item_s1.block_total <= block_total;
			item_s1.error_code  <= error_code;
			item_s1.card_state  <= card_state;
		end
	end

	sdw_step #(
		.POLL_WIDTH (POLL_WIDTH)
	) u_step (
		.ctx         (ctx_q),
		.poll_budget (poll_q),
		.item        (item_s1),
		.cfg         (cfg_q),
		.ctx_nxt     (ctx_nxt),
		.poll_nxt    (poll_nxt),
		.res         (res)
	);

	// Transfer context: update once per processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.phase         <= sdw_pkg::PH_IDLE;
			ctx_q.current_block <= 32'd0;
			ctx_q.target_count  <= 32'd0;
			ctx_q.done_count    <= 32'd0;
			ctx_q.cmd_tries     <= 8'd0;
			ctx_q.data_tries    <= 8'd0;
			poll_q              <= '0;
		end else if (fire) begin
			ctx_q  <= ctx_nxt;
			poll_q <= poll_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= res;
		end
	end

	assign result_valid     = valid_s2;
	assign action           = result_s2.action;
	assign command_argument = result_s2.command_argument;
	assign data_block_index = result_s2.data_block_index;
	assign blocks_done      = result_s2.blocks_done;
	assign result_error     = result_s2.result_error;

`ifndef SYNTHESIS
	// A finish always leaves the sequencer idle
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.action == sdw_pkg::ACT_FINISH) |=> (ctx_q.phase == sdw_pkg::PH_IDLE))
		else $error("sequencer not idle after finish");

	// While a transfer runs, fewer blocks are done than requested
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ctx_q.phase != sdw_pkg::PH_IDLE) |-> (ctx_q.done_count < ctx_q.target_count))
		else $error("done count reached target in a running transfer");

	// Programming polls always have budget left
	a_poll_left: assert property (@(posedge clk) disable iff (!arst_n)
		(ctx_q.phase == sdw_pkg::PH_PROG_STATE || ctx_q.phase == sdw_pkg::PH_TICK)
		|-> (poll_q != '0))
		else $error("poll budget empty while programming");

	// A stalled input stage means the result register is full and held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && valid_s2 && result_stall))
		else $error("input stalled without a held result");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sdw_step.sv @@
// ----------------------------------------------------------------------------
// sdw_step
// Decode one event against the current phase: pick the action and work out
// the next transfer context.
// ----------------------------------------------------------------------------
`default_nettype none

module sdw_step #(
	parameter int POLL_WIDTH = 16
) (
	input  sdw_pkg::ctx_t          ctx,
	input  logic [POLL_WIDTH-1:0]  poll_budget,
	input  sdw_pkg::item_t         item,
	input  sdw_pkg::cfg_t          cfg,
	output sdw_pkg::ctx_t          ctx_nxt,
	output logic [POLL_WIDTH-1:0]  poll_nxt,
	output sdw_pkg::result_t       res
);

	localparam int TMO_W = 16;

	logic [POLL_WIDTH-1:0] poll_masked;
	logic [POLL_WIDTH-1:0] poll_load;
	logic [POLL_WIDTH-1:0] poll_dec;
	logic [7:0]            cmd_dec;
	logic [7:0]            data_dec;
	logic [7:0]            tries_load;
	logic [31:0]           done_inc;
	logic [31:0]           next_block;

	logic start_refused;
	logic start_load;
	logic restart_block;
	logic cmd_retry;
	logic data_retry;
	logic block_done;
	logic last_block;
	logic load_poll;
	logic dec_poll;

	// Fit the timeout register to the poll budget width
	generate
		if (POLL_WIDTH > TMO_W) begin : g_poll_wide
			assign poll_masked = {{(POLL_WIDTH-TMO_W){1'b0}}, cfg.program_timeout_ms};
		end else if (POLL_WIDTH == TMO_W) begin : g_poll_same
			assign poll_masked = cfg.program_timeout_ms;
		end else begin : g_poll_narrow
			assign poll_masked = cfg.program_timeout_ms[POLL_WIDTH-1:0];
		end
	endgenerate

	assign poll_load  = (poll_masked == '0) ? POLL_WIDTH'(1) : poll_masked;
	assign poll_dec   = poll_budget - POLL_WIDTH'(1);
	assign cmd_dec    = ctx.cmd_tries - 8'd1;
	assign data_dec   = ctx.data_tries - 8'd1;
	assign tries_load = sdw_pkg::tries_init(cfg.retry_limit);
	assign done_inc   = ctx.done_count + 32'd1;
	assign next_block = ctx.current_block + 32'd1;
	assign last_block = (done_inc == ctx.target_count);

	// Choose the action for this event
	always_comb begin
		res           = '0;
		start_refused = 1'b0;
		start_load    = 1'b0;
		restart_block = 1'b0;
		cmd_retry     = 1'b0;
		data_retry    = 1'b0;
		block_done    = 1'b0;
		load_poll     = 1'b0;
		dec_poll      = 1'b0;
		unique case (item.command)
			sdw_pkg::CMD_START: begin
				if (item.error_code != sdw_pkg::ERR_NONE) begin
					// refused start: finish with nothing written
					start_refused    = 1'b1;
					res.action       = sdw_pkg::ACT_FINISH;
					res.result_error = item.error_code;
				end else begin
					start_load = 1'b1;
					if (item.block_total == 32'd0) begin
						res.action = sdw_pkg::ACT_FINISH;
					end else begin
						restart_block        = 1'b1;
						res.action           = sdw_pkg::ACT_CMD;
						res.command_argument = sdw_pkg::card_addr(cfg, item.first_block);
					end
				end
			end
			sdw_pkg::CMD_CMD_REPLY: begin
				if (ctx.phase == sdw_pkg::PH_CMD) begin
					if (item.error_code == sdw_pkg::ERR_NONE) begin
						res.action           = sdw_pkg::ACT_DATA;
						res.data_block_index = ctx.done_count;
					end else if (item.error_code == sdw_pkg::ERR_CMD_CRC ||
							item.error_code == sdw_pkg::ERR_NO_RESP) begin
						cmd_retry = 1'b1;
						if (cmd_dec != 8'd0) begin
							res.action           = sdw_pkg::ACT_CMD;
							res.command_argument = sdw_pkg::card_addr(cfg, ctx.current_block);
						end else begin
							res.action       = sdw_pkg::ACT_FINISH;
							res.blocks_done  = ctx.done_count;
							res.result_error = item.error_code;
						end
					end else if (item.error_code == sdw_pkg::ERR_RESP_CRC) begin
						res.action = sdw_pkg::ACT_STATE;
					end else begin
						res.action       = sdw_pkg::ACT_FINISH;
						res.blocks_done  = ctx.done_count;
						res.result_error = item.error_code;
					end
				end
			end
			sdw_pkg::CMD_DATA_REPLY: begin
				if (ctx.phase == sdw_pkg::PH_DATA) begin
					if (item.error_code == sdw_pkg::ERR_NONE) begin
						load_poll  = 1'b1;
						res.action = sdw_pkg::ACT_STATE;
					end else if (item.error_code == sdw_pkg::ERR_DATA_CRC) begin
						data_retry = 1'b1;
						if (data_dec != 8'd0) begin
							restart_block        = 1'b1;
							res.action           = sdw_pkg::ACT_CMD;
							res.command_argument = sdw_pkg::card_addr(cfg, ctx.current_block);
						end else begin
							res.action       = sdw_pkg::ACT_FINISH;
							res.blocks_done  = ctx.done_count;
							res.result_error = sdw_pkg::ERR_DATA_CRC;
						end
					end else begin
						res.action       = sdw_pkg::ACT_FINISH;
						res.blocks_done  = ctx.done_count;
						res.result_error = item.error_code;
					end
				end
			end
			sdw_pkg::CMD_STATE_REPLY: begin
				if (ctx.phase == sdw_pkg::PH_CMD_STATE) begin
					// card state after a reply CRC error
					if (item.error_code != sdw_pkg::ERR_NONE) begin
						res.action       = sdw_pkg::ACT_FINISH;
						res.blocks_done  = ctx.done_count;
						res.result_error = item.error_code;
					end else if (item.card_state == sdw_pkg::CST_TRANSFER) begin
						cmd_retry = 1'b1;
						if (cmd_dec != 8'd0) begin
							res.action           = sdw_pkg::ACT_CMD;
							res.command_argument = sdw_pkg::card_addr(cfg, ctx.current_block);
						end else begin
							res.action       = sdw_pkg::ACT_FINISH;
							res.blocks_done  = ctx.done_count;
							res.result_error = sdw_pkg::ERR_CMD_CRC;
						end
					end else if (item.card_state == sdw_pkg::CST_RECEIVE) begin
						res.action           = sdw_pkg::ACT_DATA;
						res.data_block_index = ctx.done_count;
					end else begin
						res.action       = sdw_pkg::ACT_FINISH;
						res.blocks_done  = ctx.done_count;
						res.result_error = sdw_pkg::ERR_GENERAL;
					end
				end else if (ctx.phase == sdw_pkg::PH_PROG_STATE) begin
					// card state while programming
					if (item.error_code != sdw_pkg::ERR_NONE) begin
						res.action       = sdw_pkg::ACT_FINISH;
						res.blocks_done  = ctx.done_count;
						res.result_error = item.error_code;
					end else if (item.card_state == sdw_pkg::CST_TRANSFER) begin
						block_done = 1'b1;
						if (last_block) begin
							res.action      = sdw_pkg::ACT_FINISH;
							res.blocks_done = done_inc;
						end else begin
							restart_block        = 1'b1;
							res.action           = sdw_pkg::ACT_CMD;
							res.command_argument = sdw_pkg::card_addr(cfg, next_block);
						end
					end else begin
						dec_poll = 1'b1;
						if (poll_dec != '0) begin
							res.action = sdw_pkg::ACT_TIMER;
						end else begin
							res.action       = sdw_pkg::ACT_FINISH;
							res.blocks_done  = ctx.done_count;
							res.result_error = sdw_pkg::ERR_TIMEOUT;
						end
					end
				end
			end
			sdw_pkg::CMD_TICK: begin
				if (ctx.phase == sdw_pkg::PH_TICK) begin
					res.action = sdw_pkg::ACT_STATE;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// Advance the transfer context
	always_comb begin
		ctx_nxt  = ctx;
		poll_nxt = poll_budget;

		unique case (res.action)
			sdw_pkg::ACT_CMD:    ctx_nxt.phase = sdw_pkg::PH_CMD;
			sdw_pkg::ACT_DATA:   ctx_nxt.phase = sdw_pkg::PH_DATA;
			sdw_pkg::ACT_STATE:  ctx_nxt.phase = (ctx.phase == sdw_pkg::PH_CMD) ?
					sdw_pkg::PH_CMD_STATE : sdw_pkg::PH_PROG_STATE;
			sdw_pkg::ACT_TIMER:  ctx_nxt.phase = sdw_pkg::PH_TICK;
			sdw_pkg::ACT_FINISH: ctx_nxt.phase = sdw_pkg::PH_IDLE;
			default:             ctx_nxt.phase = ctx.phase;
		endcase

		if (start_refused) begin
			ctx_nxt.done_count = 32'd0;
		end
		if (start_load) begin
			ctx_nxt.current_block = item.first_block;
			ctx_nxt.target_count  = item.block_total;
			ctx_nxt.done_count    = 32'd0;
			if (item.block_total != 32'd0) begin
				ctx_nxt.data_tries = tries_load;
			end
		end
		if (cmd_retry) begin
			ctx_nxt.cmd_tries = cmd_dec;
		end
		if (data_retry) begin
			ctx_nxt.data_tries = data_dec;
		end
		if (block_done) begin
			ctx_nxt.done_count = done_inc;
			if (!last_block) begin
				ctx_nxt.current_block = next_block;
				ctx_nxt.data_tries    = tries_load;
			end
		end
		if (restart_block) begin
			ctx_nxt.cmd_tries = tries_load;
		end
		if (load_poll) begin
			poll_nxt = poll_load;
		end else if (dec_poll) begin
			poll_nxt = poll_dec;
		end
	end

endmodule

`default_nettype wire
